// File: rtl/core/bds_pkg.sv
// bds_pkg: shared constants and types for the 2x2 RGBA box downsampler.
// Used by bds_ctrl, bds_lane and box_downsample_2x2_rgba.
package bds_pkg;

	localparam int REG_W = 13;               // width of the dimension registers
	localparam int CFG_IDX_W = 8;            // configuration register index width
	localparam int CHAN_W = 8;               // one color channel
	localparam int SUM_W = CHAN_W + 1;       // sum of a horizontal pair
	localparam int NUM_LANES = 4;            // R, G, B, A
	localparam int STORE_W = NUM_LANES * SUM_W;
	localparam int DIM_RESET = 256;
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

	// per-beat decisions from the position tracker
	typedef struct packed {
		logic w_one;      // single source column
		logic h_one;      // single source row
		logic load_left;  // even column: park pixel as left half
		logic wr_en;      // even row: write pair sum to line store
		logic rd_en;      // odd row: fetch upper pair sum
		logic emit;       // this beat yields an output pixel
		logic row_end;
		logic level_end;
	} bds_ctl_t;

endpackage

// File: rtl/core/bds_ram.sv
// bds_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bds_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bds_ctrl.sv
// bds_ctrl: dimension registers, column/row tracking and per-beat decisions.
// Depends on bds_pkg.
module bds_ctrl #(
	parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr,
	input  logic [bds_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bds_pkg::REG_W-1:0]             cfg_data,
	input  logic                                  acc,
	output bds_pkg::bds_ctl_t                     ctl,
	output logic [((MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] addr
);
	import bds_pkg::*;

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int DXW = $clog2(MAX_WIDTH + 1);
	localparam int DYW = $clog2(MAX_HEIGHT + 1);
	localparam int CWX = (REG_W > DXW) ? REG_W : DXW;
	localparam int CWY = (REG_W > DYW) ? REG_W : DYW;
	localparam logic [DXW-1:0] W_RST = DXW'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
	localparam logic [DYW-1:0] H_RST = DYW'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

	logic [DXW-1:0] w_q;
	logic [DYW-1:0] h_q;
	logic [XW-1:0]  x_q;
	logic [YW-1:0]  y_q;

	logic [CWX-1:0] wd_ext;
	logic [CWY-1:0] hd_ext;
	logic [DXW-1:0] w_new;
	logic [DYW-1:0] h_new;
	logic           cfg_hit;

	logic           w_one, h_one, pair, x_last, y_last;
	logic [DXW-1:0] ox, out_w_m1;
	logic [DYW-1:0] oy, out_h_m1;

	// clamp: zero acts as one, oversize acts as the maximum
	assign wd_ext = CWX'(cfg_data);
	assign hd_ext = CWY'(cfg_data);
	assign w_new = (cfg_data == '0) ? DXW'(1) :
		(wd_ext > CWX'(MAX_WIDTH)) ? DXW'(MAX_WIDTH) : DXW'(wd_ext);
	assign h_new = (cfg_data == '0) ? DYW'(1) :
		(hd_ext > CWY'(MAX_HEIGHT)) ? DYW'(MAX_HEIGHT) : DYW'(hd_ext);
	assign cfg_hit = cfg_wr && ((cfg_index == REG_SRC_WIDTH) || (cfg_index == REG_SRC_HEIGHT));

	assign w_one = (w_q == DXW'(1));
	assign h_one = (h_q == DYW'(1));
	assign pair = w_one || x_q[0];
	assign x_last = (DXW'(x_q) + DXW'(1)) >= w_q;
	assign y_last = (DYW'(y_q) + DYW'(1)) >= h_q;

	assign ox = w_one ? '0 : DXW'(x_q >> 1);
	assign oy = h_one ? '0 : DYW'(y_q >> 1);
	assign out_w_m1 = w_one ? '0 : (w_q >> 1) - DXW'(1);
	assign out_h_m1 = h_one ? '0 : (h_q >> 1) - DYW'(1);

	always_comb begin
		ctl.w_one = w_one;
		ctl.h_one = h_one;
		ctl.load_left = !w_one && !x_q[0];
		// odd trailing row of an odd height has no partner: no store write
		ctl.wr_en = pair && !h_one && !y_q[0] && !y_last;
		ctl.rd_en = pair && !h_one && y_q[0];
		ctl.emit = pair && (h_one || y_q[0]);
		ctl.row_end = (ox == out_w_m1);
		ctl.level_end = (ox == out_w_m1) && (oy == out_h_m1);
	end

	assign addr = AW'(ox);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RST;
			h_q <= H_RST;
			x_q <= '0;
			y_q <= '0;
		end else if (cfg_hit) begin
			unique case (cfg_index)
				REG_SRC_WIDTH: w_q <= w_new;
				REG_SRC_HEIGHT: h_q <= h_new;
				default: ;
			endcase
			x_q <= '0;
			y_q <= '0;
		end else if (acc) begin
			if (x_last) begin
				x_q <= '0;
				y_q <= y_last ? '0 : YW'(y_q + YW'(1));
			end else begin
				x_q <= XW'(x_q + XW'(1));
			end
		end
	end

endmodule

// File: rtl/core/bds_lane.sv
// bds_lane: one color channel - horizontal pair sum, stage-1 hold, rounded mean.
// Depends on bds_pkg.
module bds_lane (
	input  logic                        clk,
	input  logic                        load_s1,
	input  logic [bds_pkg::CHAN_W-1:0]  cur,
	input  logic [bds_pkg::CHAN_W-1:0]  left,
	input  logic                        w_one,
	input  logic                        h_one_s1,
	input  logic [bds_pkg::SUM_W-1:0]   upper,
	output logic [bds_pkg::SUM_W-1:0]   hsum,
	output logic [bds_pkg::CHAN_W-1:0]  avg
);
	import bds_pkg::*;

	logic [SUM_W-1:0] hsum_s1;
	logic [SUM_W-1:0] up;
	logic [SUM_W:0]   total;

	// single column: the pixel pairs with itself
	assign hsum = w_one ? {cur, 1'b0} : SUM_W'(cur) + SUM_W'(left);

	always_ff @(posedge clk) begin
		if (load_s1) begin
			hsum_s1 <= hsum;
		end
	end

	assign up = h_one_s1 ? hsum_s1 : upper;
	assign total = (SUM_W + 1)'(up) + (SUM_W + 1)'(hsum_s1) + (SUM_W + 1)'(2);
	assign avg = total[SUM_W:2];

endmodule

// File: rtl/core/box_downsample_2x2_rgba.sv
// box_downsample_2x2_rgba: top level of the 2x2 RGBA box-filter mip downsampler.
// Depends on bds_pkg, bds_ctrl, bds_lane and bds_ram.
//
// Takes one RGBA8 source pixel per beat in raster order and produces one mip
// level: each output pixel is the per-channel rounded mean (sum+2)>>2 of a
// 2x2 source block; an odd trailing column or row is dropped, and a width or
// height of one reuses that single column or row. The block accepts one pixel
// every clock while the output side keeps up; a pixel that completes a block
// reaches the output through the line-store read into stage 1 and then the
// output register. Input is held only while stage 1 holds a pixel and the
// output register is full behind out_stall; nothing else slows the pixel
// rate. The line store holds the upper-row pair sums, MAX_WIDTH/2 entries
// of 36 bits; every entry is written on an even row before the odd row reads
// it, so it needs no clearing pass and the block is ready right after reset.
// Configuration writes to src_width or src_height restart the position at the
// top-left pixel; cfg_ready is always high. row_end and level_end mark the
// last pixel of an output row and of the level; the position counters wrap
// for the next image on their own.
module box_downsample_2x2_rgba #(
	parameter int MAX_WIDTH = bds_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bds_pkg::REG_W-1:0]    cfg_data,
	// source pixel channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bds_pkg::CHAN_W-1:0]   red_in,
	input  logic [bds_pkg::CHAN_W-1:0]   green_in,
	input  logic [bds_pkg::CHAN_W-1:0]   blue_in,
	input  logic [bds_pkg::CHAN_W-1:0]   alpha_in,
	// result pixel channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bds_pkg::CHAN_W-1:0]   red_out,
	output logic [bds_pkg::CHAN_W-1:0]   green_out,
	output logic [bds_pkg::CHAN_W-1:0]   blue_out,
	output logic [bds_pkg::CHAN_W-1:0]   alpha_out,
	output logic                         row_end,
	output logic                         level_end
);
	import bds_pkg::*;

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bds_ctl_t           ctl;
	logic [AW-1:0]      addr;
	logic               acc;
	logic               move;

	logic [CHAN_W-1:0]  cur [NUM_LANES];
	logic [CHAN_W-1:0]  left_q [NUM_LANES];
	logic [SUM_W-1:0]   hsum [NUM_LANES];
	logic [CHAN_W-1:0]  avg [NUM_LANES];
	logic [STORE_W-1:0] wdata;
	logic [STORE_W-1:0] rdata;

	// stage 1: waiting for the line-store read
	logic               valid_s1;
	logic               h_one_s1;
	logic               row_end_s1;
	logic               level_end_s1;

	// output register
	logic               out_valid_q;
	logic [CHAN_W-1:0]  chan_q [NUM_LANES];
	logic               row_end_q;
	logic               level_end_q;

	assign cfg_ready = 1'b1;

	// hold the input only when stage 1 has a pixel that cannot move on
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign acc = in_valid && !in_stall;
	assign move = valid_s1 && (!out_valid_q || !out_stall);

	bds_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.ctl      (ctl),
		.addr     (addr)
	);

	assign cur[0] = red_in;
	assign cur[1] = green_in;
	assign cur[2] = blue_in;
	assign cur[3] = alpha_in;

	// left half of the horizontal pair
	always_ff @(posedge clk) begin
		if (acc && ctl.load_left) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				left_q[i] <= cur[i];
			end
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		bds_lane u_lane (
			.clk     (clk),
			.load_s1 (acc),
			.cur     (cur[g]),
			.left    (left_q[g]),
			.w_one   (ctl.w_one),
			.h_one_s1(h_one_s1),
			.upper   (rdata[g*SUM_W +: SUM_W]),
			.hsum    (hsum[g]),
			.avg     (avg[g])
		);
		assign wdata[g*SUM_W +: SUM_W] = hsum[g];
	end

	// upper-row pair sums, one entry per output column
	bds_ram #(
		.WIDTH(STORE_W),
		.DEPTH(DEPTH)
	) u_line (
		.clk  (clk),
		.we   (acc && ctl.wr_en),
		.waddr(addr),
		.wdata(wdata),
		.re   (acc && ctl.rd_en),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= ctl.emit;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			h_one_s1 <= ctl.h_one;
			row_end_s1 <= ctl.row_end;
			level_end_s1 <= ctl.level_end;
		end
	end

	// merge stage: lanes joined into one result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				chan_q[i] <= avg[i];
			end
			row_end_q <= row_end_s1;
			level_end_q <= level_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out = chan_q[0];
	assign green_out = chan_q[1];
	assign blue_out = chan_q[2];
	assign alpha_out = chan_q[3];
	assign row_end = row_end_q;
	assign level_end = level_end_q;

	// input is held back only by a full pipe behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled without a blocked output");

	// a pending pixel in stage 1 always lands in the output register
	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> out_valid)
		else $error("stage-1 pixel lost");

	// line store is never read and written by the same beat
	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && ctl.rd_en))
		else $error("line store read and write on one beat");

	// level end only on a row end
	a_level_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && level_end) |-> row_end)
		else $error("level_end without row_end");

endmodule

// File: test/mip_check_pkg.sv
`timescale 1ns / 1ps
// mip_check_pkg: pixel types and the scoreboard that predicts 2x2 box-filtered mip pixels.
// Depends on bds_pkg for channel widths, register indexes and dimension limits.
package mip_check_pkg;
	import bds_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;
	localparam int PAIR_DEPTH = MAX_W / 2;

	// lane 0 red, 1 green, 2 blue, 3 alpha
	typedef bit [NUM_LANES-1:0][CHAN_W-1:0] rgba_t;
	typedef bit [NUM_LANES-1:0][SUM_W-1:0] pair_sum_t;

	typedef struct {
		rgba_t color;
		bit    row_end;
		bit    level_end;
	} mip_px_t;

	class mip_scoreboard;
		bit [REG_W-1:0] width_reg;
		bit [REG_W-1:0] height_reg;
		pair_sum_t      upper_sums [PAIR_DEPTH];
		rgba_t          left_px;
		int unsigned    col;
		int unsigned    row;
		mip_px_t        mip_q [$];
		int             errors;
		int             pixels;
		int             checked;
		int             row_ends;
		int             level_ends;

		function new();
			width_reg = REG_W'(DIM_RESET);
			height_reg = REG_W'(DIM_RESET);
			left_px = '0;
			col = 0;
			row = 0;
			errors = 0;
			pixels = 0;
			checked = 0;
			row_ends = 0;
			level_ends = 0;
		endfunction

		// 0 behaves as 1, anything past the limit as the limit
		static function int unsigned eff_dim(bit [REG_W-1:0] v, int unsigned lim);
			if (v == 0)
				return 1;
			if (v > lim)
				return lim;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [REG_W-1:0] val);
			if (idx == REG_SRC_WIDTH)
				width_reg = val;
			else if (idx == REG_SRC_HEIGHT)
				height_reg = val;
			else
				return;
			col = 0;
			row = 0;
		endfunction

		function void note_pixel(rgba_t px);
			int unsigned w, h, out_w, out_h, ox, oy;
			bit          have_pair;
			bit          emit;
			pair_sum_t   hsum;
			pair_sum_t   upper;
			mip_px_t     res;
			bit [SUM_W:0] total;
			w = eff_dim(width_reg, MAX_W);
			h = eff_dim(height_reg, MAX_H);
			out_w = (w < 2) ? 1 : w / 2;
			out_h = (h < 2) ? 1 : h / 2;
			ox = (w == 1) ? 0 : col / 2;
			oy = (h == 1) ? 0 : row / 2;
			have_pair = 1'b0;
			emit = 1'b0;
			hsum = '0;
			upper = '0;
			pixels++;

			if (w == 1) begin
				for (int c = 0; c < NUM_LANES; c++)
					hsum[c] = {px[c], 1'b0};
				have_pair = 1'b1;
			end else if (col % 2 == 0) begin
				left_px = px;
			end else begin
				for (int c = 0; c < NUM_LANES; c++)
					hsum[c] = SUM_W'(left_px[c]) + SUM_W'(px[c]);
				have_pair = 1'b1;
			end

			if (have_pair && ox < out_w && oy < out_h) begin
				upper = hsum;
				if (h == 1) begin
					emit = 1'b1;
				end else if (row % 2 == 0) begin
					upper_sums[ox] = hsum;
				end else begin
					upper = upper_sums[ox];
					emit = 1'b1;
				end
			end

			if (emit) begin
				for (int c = 0; c < NUM_LANES; c++) begin
					total = (SUM_W + 1)'(upper[c]) + (SUM_W + 1)'(hsum[c]) +
						(SUM_W + 1)'(2);
					res.color[c] = total[SUM_W:2];
				end
				res.row_end = (ox == out_w - 1);
				res.level_end = res.row_end && (oy == out_h - 1);
				mip_q.insert(mip_q.size(), res);
			end

			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void check_result(mip_px_t got);
			mip_px_t want;
			string   lane_name [NUM_LANES];
			lane_name = '{"red_out", "green_out", "blue_out", "alpha_out"};
			if (mip_q.size() == 0) begin
				$error("result beat with no pixel outstanding: rgba %h", got.color);
				errors++;
				return;
			end
			want = mip_q.pop_front();
			checked++;
			for (int c = 0; c < NUM_LANES; c++) begin
				if (got.color[c] != want.color[c]) begin
					$error("%s: expected %0d, got %0d", lane_name[c], want.color[c],
						got.color[c]);
					errors++;
				end
			end
			if (got.row_end != want.row_end) begin
				$error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
				errors++;
			end
			if (got.level_end != want.level_end) begin
				$error("level_end: expected %0d, got %0d", want.level_end, got.level_end);
				errors++;
			end
			if (want.row_end)
				row_ends++;
			if (want.level_end)
				level_ends++;
		endfunction

		function int pending();
			return mip_q.size();
		endfunction
	endclass

endpackage

// File: test/tb_box_downsample_2x2_rgba.sv
`timescale 1ns / 1ps
// tb_box_downsample_2x2_rgba: self-checking bench for the 2x2 RGBA mip downsampler.
// Depends on bds_pkg, mip_check_pkg and the box_downsample_2x2_rgba RTL.
module tb_box_downsample_2x2_rgba;
	import bds_pkg::*;
	import mip_check_pkg::*;

	localparam int QUIET_LIMIT = 2000;    // cycles with no beat on any channel
	localparam int DRAIN_CYCLES = 6;      // dropped pixels may still be in flight
	localparam int LARGE_PIXELS = 150;    // start of a clamped maximum-size image
	localparam int RANDOM_PIXELS = 400;
	localparam int CALM_PIXELS = 120;     // tail of the random part runs with no sender gaps or receiver stalls
	localparam int MAX_IMAGE_PIXELS = 100;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [CHAN_W-1:0]    red_in;
	logic [CHAN_W-1:0]    green_in;
	logic [CHAN_W-1:0]    blue_in;
	logic [CHAN_W-1:0]    alpha_in;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [CHAN_W-1:0]    red_out;
	logic [CHAN_W-1:0]    green_out;
	logic [CHAN_W-1:0]    blue_out;
	logic [CHAN_W-1:0]    alpha_out;
	logic                 row_end;
	logic                 level_end;

	mip_scoreboard sb;
	mip_px_t       seen_px;
	int            gap_pct = 0;      // chance per pixel of a sender gap burst
	int            stall_pct = 0;    // chance per cycle of a receiver stall burst
	int            stall_left = 0;
	int            quiet = 0;
	int            settings = 0;

	box_downsample_2x2_rgba dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.alpha_in  (alpha_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.alpha_out (alpha_out),
		.row_end   (row_end),
		.level_end (level_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver back-pressure: stall bursts. A burst is started here, and
	// stall_left holds out_stall high until it has counted down to zero.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result monitor: values seen here are the ones from before this edge, so
	// a beat is exactly what the block saw as accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_px.color = {alpha_out, blue_out, green_out, red_out};
			seen_px.row_end = row_end;
			seen_px.level_end = level_end;
			sb.check_result(seen_px);
		end
	end

	// Watchdog: any beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
				QUIET_LIMIT, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Mostly random channel values, with the two extremes weighted in.
	function automatic rgba_t rand_pixel();
		rgba_t px;
		for (int c = 0; c < NUM_LANES; c++) begin
			case ($urandom_range(7))
				0:       px[c] = '0;
				1:       px[c] = '1;
				default: px[c] = CHAN_W'($urandom_range(255));
			endcase
		end
		return px;
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2))
			0:       return 0;
			1:       return 15;
			default: return 40;
		endcase
	endfunction

	// Holds the beat until the block takes it; valid is left high so the next
	// pixel can follow back to back.
	task automatic send_pixel(rgba_t px);
		in_valid <= 1'b1;
		{alpha_in, blue_in, green_in, red_in} <= px;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(px);
	endtask

	// Block must be idle for a register write: all results in, plus a few
	// cycles for a trailing pixel that yields nothing.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both dimension registers; either write restarts the image.
	task automatic set_dims(bit [REG_W-1:0] w, bit [REG_W-1:0] h);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_SRC_WIDTH, w);
		cfg_index <= REG_SRC_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_SRC_HEIGHT, h);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Random pixels with sender gap bursts; optionally the sender stops halfway
	// and waits for every outstanding result before going on.
	task automatic feed_random(int unsigned count, bit pause_midway);
		for (int unsigned i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end else if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(5, 1)) @(posedge clk);
			end
			send_pixel(rand_pixel());
		end
	endtask

	initial begin
		int unsigned w, h, area, count, random_done;
		sb = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		alpha_in = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// 3x3: odd trailing column and row are dropped, one output pixel.
		// Block mixes all-zero, all-one and small values to probe rounding.
		set_dims(3, 3);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h1234_5678);    // dropped column
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0102_0304);
		send_pixel(32'hAAAA_AAAA);    // dropped column
		send_pixel(32'h5555_5555);    // dropped row
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		// counters wrapped: start a second image, then cut it short with a
		// register write, which must restart at the top-left pixel
		send_pixel(32'h8080_8080);
		send_pixel(32'h7F7F_7F7F);
		send_pixel(32'h0303_0303);
		send_pixel(32'h0101_0101);

		// width 0 acts as 1: the single column is doubled
		set_dims(0, 2);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		// height 0 acts as 1: the single row is doubled
		set_dims(2, 0);
		send_pixel(32'h5555_5555);
		send_pixel(32'hAAAA_AAAA);
		// 2x2 with sums that land on the rounding boundary
		set_dims(2, 2);
		send_pixel(32'h0100_0201);
		send_pixel(32'h0001_0000);
		send_pixel(32'h0000_0001);
		send_pixel(32'h8000_FF02);
		// 1x1: the one pixel ends both the row and the level
		set_dims(1, 1);
		send_pixel(32'hFFFF_FFFF);

		// --- largest sizes, values past the limit clamp to it ---
		gap_pct = 10;
		stall_pct = 10;
		set_dims('1, '0);             // 4096 x 1, first part of the row
		feed_random(LARGE_PIXELS, 1'b0);
		set_dims('0, '1);             // 1 x 4096, first rows
		feed_random(LARGE_PIXELS, 1'b0);

		// --- random part: small images, full or cut short ---
		random_done = 0;
		while (random_done < RANDOM_PIXELS) begin
			if (random_done >= RANDOM_PIXELS - CALM_PIXELS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = pick_pct();
				stall_pct = pick_pct();
			end
			if ($urandom_range(4) == 0) begin
				w = $urandom_range(64, 13);
				h = $urandom_range(4, 1);
			end else begin
				w = $urandom_range(12);
				h = $urandom_range(12);
			end
			area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			// mostly whole images (wrap included), sometimes a partial one
			if ($urandom_range(3) == 0)
				count = $urandom_range(2 * area, 1);
			else
				count = area * $urandom_range(3, 1);
			if (count > MAX_IMAGE_PIXELS)
				count = MAX_IMAGE_PIXELS;
			set_dims(REG_W'(w), REG_W'(h));
			feed_random(count, random_done == 0 || $urandom_range(4) == 0);
			random_done += count;
		end

		wait_drained();
		$display("Covered %0d source pixels under %0d dimension settings (1x1 to 4096 wide/tall)",
			sb.pixels, settings);
		$display("Checked %0d mip pixels, %0d row ends, %0d level ends",
			sb.checked, sb.row_ends, sb.level_ends);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
